// ===== sv/qwsg_pkg.sv =====
// ----------------------------------------------------------------------------
// qwsg_pkg: quarter-wave sine generator package
// Phase and table constants, the quarter-sine ROM and register indexes.
// ----------------------------------------------------------------------------
package qwsg_pkg;

  localparam int unsigned QUARTER_POINTS      = 20;
  localparam int unsigned PHASE_FRACTION_BITS = 16;

  localparam int unsigned PHASE_W  = 23;
  localparam int unsigned SUM_W    = PHASE_W + 1;
  localparam int unsigned IDX_W    = 21;
  localparam int unsigned ROMA_W   = 5;
  localparam int unsigned ROMD_W   = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned PROD_W   = 48;

  localparam int unsigned QUARTER_SPAN_I = QUARTER_POINTS << PHASE_FRACTION_BITS;

  localparam logic [PHASE_W-1:0] QUARTER_SPAN = PHASE_W'(QUARTER_SPAN_I);
  localparam logic [PHASE_W-1:0] HALF_SPAN    = PHASE_W'(2 * QUARTER_SPAN_I);
  localparam logic [PHASE_W-1:0] THREEQ_SPAN  = PHASE_W'(3 * QUARTER_SPAN_I);
  localparam logic [PHASE_W-1:0] PERIOD_SPAN  = PHASE_W'(4 * QUARTER_SPAN_I);

  // rounding half of the final shift
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (PHASE_FRACTION_BITS + 14);

  // register index, taken from paddr[2]
  localparam logic REG_AMPLITUDE = 1'b0;
  localparam logic REG_OFFSET    = 1'b1;

  // quarter sine, unsigned Q1.15; reads past the end return the last entry
  function automatic logic [ROMD_W-1:0] rom_value(input logic [ROMA_W-1:0] addr);
    logic [ROMD_W-1:0] v;
    case (addr)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd2571;
      5'd2:    v = 16'd5126;
      5'd3:    v = 16'd7650;
      5'd4:    v = 16'd10126;
      5'd5:    v = 16'd12540;
      5'd6:    v = 16'd14876;
      5'd7:    v = 16'd17121;
      5'd8:    v = 16'd19261;
      5'd9:    v = 16'd21281;
      5'd10:   v = 16'd23170;
      5'd11:   v = 16'd24917;
      5'd12:   v = 16'd26510;
      5'd13:   v = 16'd27939;
      5'd14:   v = 16'd29197;
      5'd15:   v = 16'd30274;
      5'd16:   v = 16'd31164;
      5'd17:   v = 16'd31863;
      5'd18:   v = 16'd32365;
      5'd19:   v = 16'd32667;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/quarter_wave_sine_generator.sv =====
// An accepted beat steps through S_WRAP, S_FOLD, S_ROM, S_MUL1, S_MAG, S_MUL2 and
// S_OUT; no new beat is taken before S_IDLE. A single shared 32x16 multiplier is used
// twice per sample (interpolation, then amplitude scaling) under the sequencer.
// Output register frees the input side while a sample waits to be taken.
// Reset (rst, synchronous): phase, amplitude and offset_level cleared, no beat held.
// ----------------------------------------------------------------------------
// quarter_wave_sine_generator: DDS sine from a quarter-wave table
// Phase accumulate, fold, linear interpolation, scale, offset and saturate.
// ----------------------------------------------------------------------------
module quarter_wave_sine_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [22:0] phase_step
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qwsg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WRAP = 8'b0000_0010,
    S_FOLD = 8'b0000_0100,
    S_ROM  = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MAG  = 8'b0010_0000,
    S_MUL2 = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [AMP_W-1:0]           amplitude;
  logic signed [SAMPLE_W-1:0] offset_level;
  logic [PHASE_W-1:0]         phase;
  logic [SUM_W-1:0]           sum;
  logic [IDX_W-1:0]           idx;
  logic                       neg;
  logic [ROMD_W-1:0]          rom_lo;
  logic [ROMD_W-1:0]          rom_diff;
  logic [MAG_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;

  logic [PHASE_W-1:0]         step_c;
  logic [ROMA_W-1:0]          i1;
  logic [ROMA_W-1:0]          i2;
  logic [MAG_W-1:0]           mul_a;
  logic [ROMD_W-1:0]          mul_b;
  logic [PROD_W-1:0]          rnd;
  logic [16:0]                scaled;
  logic signed [17:0]         value;
  logic [SAMPLE_W-1:0]        sat;
  logic                       cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    if (paddr[2] == REG_OFFSET) begin
      prdata = {16'b0, offset_level};
    end else begin
      prdata = {17'b0, amplitude};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= '0;
      offset_level <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_AMPLITUDE) begin
        amplitude <= pwdata[AMP_W-1:0];
      end else begin
        offset_level <= pwdata[SAMPLE_W-1:0];
      end
    end
  end

  // datapath helpers
  assign s_tready = (state == S_IDLE);
  assign step_c   = (s_tdata[PHASE_W-1:0] > PERIOD_SPAN) ? PERIOD_SPAN
                                                         : s_tdata[PHASE_W-1:0];
  assign i1 = idx[IDX_W-1:PHASE_FRACTION_BITS];
  assign i2 = i1 + ROMA_W'(1);

  // shared multiplier
  assign mul_a = (state == S_MUL2) ? mag : {16'b0, rom_diff};
  assign mul_b = (state == S_MUL2) ? {1'b0, amplitude} : idx[PHASE_FRACTION_BITS-1:0];

  assign rnd    = prod + ROUND_HALF;
  assign scaled = rnd[PROD_W-1:PHASE_FRACTION_BITS+15];
  assign value  = neg ? (18'(offset_level) - $signed({1'b0, scaled}))
                      : (18'(offset_level) + $signed({1'b0, scaled}));

  always_comb begin
    if (value > 18'sd32767) begin
      sat = 16'h7FFF;
    end else if (value < -18'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = value[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_WRAP;
      S_WRAP: state_next = S_FOLD;
      S_FOLD: state_next = S_ROM;
      S_ROM:  state_next = S_MUL1;
      S_MUL1: state_next = S_MAG;
      S_MAG:  state_next = S_MUL2;
      S_MUL2: state_next = S_OUT;
      S_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_WRAP) begin
        if (sum > {1'b0, PERIOD_SPAN}) begin
          phase <= PHASE_W'(sum - {1'b0, PERIOD_SPAN});
        end else begin
          phase <= sum[PHASE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: sum <= {1'b0, phase} + {1'b0, step_c};
      S_FOLD: begin
        if (phase < QUARTER_SPAN) begin
          idx <= phase[IDX_W-1:0];
          neg <= 1'b0;
        end else if (phase < HALF_SPAN) begin
          idx <= IDX_W'(HALF_SPAN - phase);
          neg <= 1'b0;
        end else if (phase < THREEQ_SPAN) begin
          idx <= IDX_W'(phase - HALF_SPAN);
          neg <= 1'b1;
        end else begin
          idx <= IDX_W'(PERIOD_SPAN - phase);
          neg <= 1'b1;
        end
      end
      S_ROM: begin
        rom_lo   <= rom_value(i1);
        rom_diff <= rom_value(i2) - rom_value(i1);
      end
      S_MUL1: prod <= mul_a * {16'b0, mul_b};
      S_MAG:  mag  <= {rom_lo, 16'b0} + prod[MAG_W-1:0];
      S_MUL2: prod <= mul_a * {16'b0, mul_b};
      S_OUT:  if (!m_tvalid || m_tready) m_tdata <= sat;
      default: ;
    endcase
  end

  // checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PERIOD_SPAN)
    else $error("phase accumulator beyond one period");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_WRAP)
    else $error("accepted beat did not start the sequence");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROM |-> idx <= QUARTER_SPAN[IDX_W-1:0])
    else $error("folded index outside the quarter");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL2 |-> mag <= 32'h8000_0000)
    else $error("interpolated magnitude above unity");

endmodule

// ===== tb/quarter_wave_sine_generator_test.sv =====
// ----------------------------------------------------------------------------
// quarter_wave_sine_generator_test: self-checking bench for the sine generator
// Drives phase steps on the input stream and register writes on the APB port,
// predicts every sample from a bit-exact phase accumulator, fold,
// interpolation and saturation model, and checks each output beat in order.
// ----------------------------------------------------------------------------
module quarter_wave_sine_generator_test;
  import qwsg_pkg::*;

  localparam longint unsigned QSPAN  = longint'(QUARTER_POINTS) << PHASE_FRACTION_BITS;
  localparam longint unsigned PERIOD = 4 * QSPAN;
  localparam longint unsigned FONE   = longint'(1) << PHASE_FRACTION_BITS;

  class sine_sample_board;
    int unsigned quarter_sine [0:20] = '{
      0, 2571, 5126, 7650, 10126, 12540, 14876, 17121, 19261, 21281, 23170,
      24917, 26510, 27939, 29197, 30274, 31164, 31863, 32365, 32667, 32768
    };
    longint unsigned phase_acc;
    longint unsigned amplitude;
    longint          offset_level;
    logic [15:0]     expected_samples [$];
    int              mismatches;
    int              steps_seen;
    int              samples_seen;

    function new();
      phase_acc    = 0;
      amplitude    = 0;
      offset_level = 0;
      mismatches   = 0;
      steps_seen   = 0;
      samples_seen = 0;
    endfunction

    function void set_register(logic sel, logic [31:0] value);
      if (sel == REG_AMPLITUDE) amplitude = value[14:0];
      else offset_level = longint'($signed(value[15:0]));
    endfunction

    function longint unsigned table_at(longint unsigned pos);
      if (pos > QUARTER_POINTS) pos = QUARTER_POINTS;
      return quarter_sine[pos];
    endfunction

    function void note_step(logic [22:0] step_in);
      longint unsigned step, idx, whole, frac, mag, scaled;
      longint          value;
      bit              negative;
      step = step_in;
      steps_seen++;
      if (step > PERIOD) step = PERIOD;
      phase_acc = phase_acc + step;
      if (phase_acc > PERIOD) phase_acc = phase_acc - PERIOD;
      negative = phase_acc >= 2 * QSPAN;
      if (phase_acc < QSPAN) idx = phase_acc;
      else if (phase_acc < 2 * QSPAN) idx = 2 * QSPAN - phase_acc;
      else if (phase_acc < 3 * QSPAN) idx = phase_acc - 2 * QSPAN;
      else idx = PERIOD - phase_acc;
      whole  = idx >> PHASE_FRACTION_BITS;
      frac   = idx & (FONE - 1);
      mag    = table_at(whole) * (FONE - frac) + table_at(whole + 1) * frac;
      scaled = (mag * amplitude + (longint'(1) << (PHASE_FRACTION_BITS + 14)))
               >> (PHASE_FRACTION_BITS + 15);
      value  = negative ? offset_level - longint'(scaled) : offset_level + longint'(scaled);
      if (value > 32767) value = 32767;
      if (value < -32768) value = -32768;
      expected_samples.push_back(value[15:0]);
    endfunction

    function void check_sample(logic [15:0] got);
      logic [15:0] want;
      samples_seen++;
      if (expected_samples.size() == 0) begin
        $error("sample beat with nothing expected: actual %0d", $signed(got));
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        $error("sample mismatch: expected %0d, actual %0d", $signed(want), $signed(got));
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [22:0] phase_step
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] sample
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sine_sample_board board = new();
  bit calm_tx;
  bit calm_rx;
  bit hold_req;
  int hold_left;
  int settings_run;

  quarter_wave_sine_generator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample receiver: random back-pressure, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      m_tready  = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = calm_rx || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_step(s_tdata[22:0]);
      if (m_tvalid && m_tready) board.check_sample(m_tdata);
    end
  end

  task automatic write_reg(input logic sel, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    board.set_register(sel, value);
  endtask

  task automatic send_step(input logic [22:0] step);
    while (!calm_tx && $urandom_range(99) < 12) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, step};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  function automatic logic [22:0] random_step();
    case ($urandom_range(9))
      0: return 23'($urandom_range(0, 32'hFFFF));
      1: return 23'($urandom_range(0, 4 * QUARTER_POINTS) << PHASE_FRACTION_BITS);
      2: return 23'($urandom_range(1, 4) * QSPAN);
      3: return 23'($urandom_range(32'(PERIOD), 32'h7FFFFF));
      4: return 23'h7FFFFF;
      default: return 23'($urandom_range(0, 32'(PERIOD)));
    endcase
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_step(random_step());
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic new_setting(input logic [31:0] amp, input logic [31:0] off);
    wait_drained();
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_OFFSET, off);
    settings_run++;
  endtask

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [22:0] directed [$];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    calm_tx  = 1'b0;
    calm_rx  = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    settings_run = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full scale, no offset: folding, table end, wrap and step limiting
    new_setting(32'd32767, 32'd0);
    directed = '{23'd0, 23'(QSPAN), 23'(QSPAN), 23'(QSPAN), 23'(QSPAN), 23'd1,
                 23'h7FFFFF, 23'(PERIOD), 23'(PERIOD - 1), 23'(FONE), 23'h8000,
                 23'(PERIOD + 1), 23'(QSPAN - 1), 23'd2, 23'h7FFFFF, 23'h555555,
                 23'h2AAAAA, 23'(FONE / 2 * 3)};
    foreach (directed[i]) send_step(directed[i]);
    run_random(200);
    calm_tx = 1'b1;
    calm_rx = 1'b1;
    run_random(150);
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    // output side stalled while input keeps offering beats
    @(negedge clk);
    hold_req = 1'b1;
    run_random(40);
    wait_drained();
    run_random(100);

    // saturation at both rails, then zero and minimum nonzero amplitude
    new_setting(32'd32767, 32'd32767);
    send_step(23'(QSPAN));
    run_random(150);
    new_setting(32'd32767, 32'hFFFF8000);
    send_step(23'(2 * QSPAN));
    run_random(150);
    new_setting(32'd0, 32'd5);
    run_random(60);
    new_setting(32'd1, 32'hFFFFFFFF);
    run_random(100);

    repeat (4) begin
      new_setting($urandom, $urandom);
      run_random(130);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d phase steps and %0d output samples over %0d register settings.",
             board.steps_seen, board.samples_seen, settings_run);
    $display("Mismatches: %0d, samples still outstanding: %0d",
             board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
